### src/fpa_pkg.sv
// shared opcodes, result kinds and divider constants for the fixed-point alu
package fpa_pkg;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} func_t;

	typedef enum logic [1:0] {
		KIND_SIMPLE = 2'd0,
		KIND_MUL    = 2'd1,
		KIND_DIV    = 2'd2
	} kind_t;

	// quotient bits resolved per divider stage
	localparam int DIV_STEPS = 8;

endpackage

### src/fpa_div_stage.sv
// one registered stage of the restoring divider, several quotient bits per stage
module fpa_div_stage #(
	parameter int WB  = 32,
	parameter int QB  = 40,
	parameter int TOP = 39,
	parameter int MW  = 101
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          valid_i,
	input  logic [QB-1:0] n_i,
	input  logic [WB-1:0] d_i,
	input  logic [WB-1:0] r_i,
	input  logic [QB-1:0] q_i,
	input  logic [MW-1:0] meta_i,
	output logic          valid_s,
	output logic [QB-1:0] n_s,
	output logic [WB-1:0] d_s,
	output logic [WB-1:0] r_s,
	output logic [QB-1:0] q_s,
	output logic [MW-1:0] meta_s
);

	logic [WB-1:0] r_c;
	logic [QB-1:0] q_c;
	logic [WB:0]   t_c;

	always_comb begin
		r_c = r_i;
		q_c = q_i;
		t_c = '0;
		for (int j = 0; j < fpa_pkg::DIV_STEPS; j++) begin
			if (TOP - j >= 0) begin
				t_c = {r_c, n_i[TOP - j]};
				if (t_c >= {1'b0, d_i}) begin
					t_c = t_c - {1'b0, d_i};
					q_c[TOP - j] = 1'b1;
				end
				r_c = t_c[WB-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (adv) begin
			valid_s <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s    <= n_i;
			d_s    <= d_i;
			r_s    <= r_c;
			q_s    <= q_c;
			meta_s <= meta_i;
		end
	end

endmodule

### src/fixed_point_alu_q24_8.sv
// top level: signed fixed-point alu with input register, operate stage, divider and output register
// every operation, not only division, passes through the whole divider chain to the output register
// throughput: one transaction per cycle while the output is not stalled; the divider chain is fully pipelined
// a stalled output freezes the whole pipeline and holds off new input transactions
// reset clears every valid bit; payload registers are not reset
module fixed_point_alu_q24_8 #(
	parameter int FRAC_BITS = 8,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  func,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	output logic        compare_true,
	output logic        divide_by_zero
);

	localparam int WB  = WORD_BITS;
	localparam int QB  = WORD_BITS + FRAC_BITS;
	localparam int NST = (QB + fpa_pkg::DIV_STEPS - 1) / fpa_pkg::DIV_STEPS;
	localparam int MW  = 3 * WB + 5;

	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// input register
	logic                 valid_s1;
	fpa_pkg::func_t       func_s1;
	logic signed [WB-1:0] a_s1;
	logic signed [WB-1:0] b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= fpa_pkg::func_t'(func);
			a_s1    <= operand_a[WB-1:0];
			b_s1    <= operand_b[WB-1:0];
		end
	end

	// operate stage
	logic signed [2*WB-1:0] prod_c;
	logic [WB-1:0]          abs_a;
	logic [WB-1:0]          abs_b;
	logic [WB-1:0]          simple_c;
	logic                   cmp_c;
	logic                   dz_c;
	logic                   neg_c;
	fpa_pkg::kind_t         kind_c;

	always_comb begin
		prod_c   = a_s1 * b_s1;
		abs_a    = a_s1[WB-1] ? WB'(-a_s1) : WB'(a_s1);
		abs_b    = b_s1[WB-1] ? WB'(-b_s1) : WB'(b_s1);
		neg_c    = a_s1[WB-1] ^ b_s1[WB-1];
		dz_c     = 1'b0;
		cmp_c    = 1'b0;
		simple_c = '0;
		kind_c   = fpa_pkg::KIND_SIMPLE;
		case (func_s1)
			fpa_pkg::OP_ADD:      simple_c = a_s1 + b_s1;
			fpa_pkg::OP_SUB:      simple_c = a_s1 - b_s1;
			fpa_pkg::OP_MUL:      kind_c = fpa_pkg::KIND_MUL;
			fpa_pkg::OP_DIV: begin
				if (b_s1 == '0) begin
					dz_c = 1'b1;
				end else begin
					kind_c = fpa_pkg::KIND_DIV;
				end
			end
			fpa_pkg::OP_GT:       cmp_c = a_s1 > b_s1;
			fpa_pkg::OP_LT:       cmp_c = a_s1 < b_s1;
			fpa_pkg::OP_GE:       cmp_c = a_s1 >= b_s1;
			fpa_pkg::OP_LE:       cmp_c = a_s1 <= b_s1;
			fpa_pkg::OP_EQ:       cmp_c = a_s1 == b_s1;
			fpa_pkg::OP_NE:       cmp_c = a_s1 != b_s1;
			fpa_pkg::OP_MIN:      simple_c = (a_s1 > b_s1) ? b_s1 : a_s1;
			fpa_pkg::OP_MAX:      simple_c = (a_s1 > b_s1) ? a_s1 : b_s1;
			fpa_pkg::OP_INC:      simple_c = a_s1 + WB'(1);
			fpa_pkg::OP_DEC:      simple_c = a_s1 - WB'(1);
			fpa_pkg::OP_FROM_INT: simple_c = a_s1 << FRAC_BITS;
			fpa_pkg::OP_TO_INT:   simple_c = a_s1 >>> FRAC_BITS;
			default:              simple_c = '0;
		endcase
	end

	logic          valid_p [0:NST];
	logic [QB-1:0] n_p     [0:NST];
	logic [WB-1:0] d_p     [0:NST];
	logic [WB-1:0] r_p     [0:NST];
	logic [QB-1:0] q_p     [0:NST];
	logic [MW-1:0] meta_p  [0:NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_p[0] <= 1'b0;
		end else if (adv) begin
			valid_p[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_p[0]    <= {abs_a, {FRAC_BITS{1'b0}}};
			d_p[0]    <= abs_b;
			r_p[0]    <= '0;
			q_p[0]    <= '0;
			meta_p[0] <= {prod_c, simple_c, cmp_c, dz_c, neg_c, kind_c};
		end
	end

	// divider chain
	for (genvar k = 1; k <= NST; k++) begin : g_div
		fpa_div_stage #(
			.WB  (WB),
			.QB  (QB),
			.TOP (QB - 1 - (k - 1) * fpa_pkg::DIV_STEPS),
			.MW  (MW)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.valid_i (valid_p[k-1]),
			.n_i     (n_p[k-1]),
			.d_i     (d_p[k-1]),
			.r_i     (r_p[k-1]),
			.q_i     (q_p[k-1]),
			.meta_i  (meta_p[k-1]),
			.valid_s (valid_p[k]),
			.n_s     (n_p[k]),
			.d_s     (d_p[k]),
			.r_s     (r_p[k]),
			.q_s     (q_p[k]),
			.meta_s  (meta_p[k])
		);
	end

	// result select
	logic signed [2*WB-1:0] prod_f;
	logic signed [2*WB-1:0] adj_f;
	logic signed [2*WB-1:0] shr_f;
	logic [WB-1:0]          simple_f;
	logic                   cmp_f;
	logic                   dz_f;
	logic                   neg_f;
	logic [1:0]             kind_bits_f;
	fpa_pkg::kind_t         kind_f;
	logic [WB-1:0]          qw_f;
	logic [WB-1:0]          res_f;

	always_comb begin
		{prod_f, simple_f, cmp_f, dz_f, neg_f, kind_bits_f} = meta_p[NST];
		kind_f = fpa_pkg::kind_t'(kind_bits_f);
		// bias negative products so the shift truncates toward zero
		adj_f = prod_f + (prod_f[2*WB-1] ? {{(2*WB-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}}
			: {(2*WB){1'b0}});
		shr_f = adj_f >>> FRAC_BITS;
		qw_f  = q_p[NST][WB-1:0];
		case (kind_f)
			fpa_pkg::KIND_MUL: res_f = shr_f[WB-1:0];
			fpa_pkg::KIND_DIV: res_f = neg_f ? WB'(-qw_f) : qw_f;
			default:           res_f = simple_f;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_p[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value          <= 32'($signed(res_f));
			compare_true   <= cmp_f;
			divide_by_zero <= dz_f;
		end
	end

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> value == 32'd0)
		else $error("divide by zero with nonzero value");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(compare_true && divide_by_zero))
		else $error("compare and divide flags both set");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> out_valid && $stable(value))
		else $error("pipeline moved while stalled");

	a_cmp_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && compare_true |-> value == 32'd0)
		else $error("comparison with nonzero value");

endmodule
